[hw/rtl/tfhs_pkg.sv]
// shared types and constants of the tcp funnel header stripper
`default_nettype none
package tfhs_pkg;

  localparam int HEADER_BEATS = 39;
  localparam int STRIP_BYTES  = 20;
  localparam int STRIP_BEATS  = STRIP_BYTES / 2;
  localparam int IDX_W        = $clog2(HEADER_BEATS + 1);

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // beat positions inside the header buffer
  localparam logic [IDX_W-1:0] BEAT_ETYPE = IDX_W'(6);
  localparam logic [IDX_W-1:0] BEAT_VIHL  = IDX_W'(7);
  localparam logic [IDX_W-1:0] BEAT_TOT   = IDX_W'(8);
  localparam logic [IDX_W-1:0] BEAT_PROTO = IDX_W'(11);
  localparam logic [IDX_W-1:0] BEAT_CSUM  = IDX_W'(12);
  localparam logic [IDX_W-1:0] BEAT_LAST_IP = IDX_W'(16);

  // configuration register indexes
  localparam logic [1:0] CFG_DST_PORT    = 2'd0;
  localparam logic [1:0] CFG_SRC_PORT    = 2'd1;
  localparam logic [1:0] CFG_INNER_PROTO = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_UNFUN = 2'd1,
    VERDICT_DROP  = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    CNT_SEEN = 2'd0,   // all beats buffered so far
    CNT_HDR  = 2'd1,   // ethernet and ip header only
    CNT_ALL  = 2'd2    // header plus both port words
  } cnt_sel_e;

  typedef enum logic [2:0] {
    ST_COLLECT  = 3'd0,
    ST_STRIP    = 3'd1,
    ST_FWD      = 3'd2,
    ST_FLUSH_RD = 3'd3,
    ST_FLUSH_LD = 3'd4
  } state_e;

  typedef struct packed {
    logic     coll_acc;
    logic     strip_acc;
    logic     fwd_emit;
    logic     rewrite;
    logic     fl_start;
    logic     fl_load;
    logic     new_frame;
    cnt_sel_e cnt_sel;
    logic [1:0] fl_bytes;
    logic     fl_last;
    verdict_e fl_verdict;
  } cmd_t;

  typedef struct packed {
    logic at_etype;
    logic at_ip_end;
    logic at_ports;
    logic is_ip;
    logic hdr_ok;
    logic ports_match;
    logic tot_short;
    logic strip_done;
    logic fl_final;
    logic fl_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/tcp_funnel_header_stripper.sv]
// top level of the tcp funnel header stripper
//
//  channel   direction  handshake              contents
//  s_axis    in         tvalid/tready, tlast   tdata: [15:0] beat data, [17:16] byte count
//  m_axis    out        tvalid/tready, tlast   tdata: [15:0] data, [17:16] bytes; tuser verdict
//  cfg       in         cfg_we_i               index 0 dst port, 1 src port, 2 inner proto
//
// header words are taken one per cycle while buffering, forwarded words one per cycle, while m_axis is free
// each buffered word of a flush passes a read state and then a load state (registered memory read)
// a flush of up to 39 words follows the deciding word; no words are taken meanwhile
// reset restores register defaults; the header buffer itself is not cleared
// a stalled m_axis holds the output register and blocks s_axis
`default_nettype none
module tcp_funnel_header_stripper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [15:0] beat_data, [17:16] beat_bytes
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] out_data, [17:16] out_bytes
  output logic [1:0]       m_axis_tuser,   // [1:0] verdict
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  tfhs_pkg::cmd_t    cmd;
  tfhs_pkg::status_t status;
  logic [15:0] out_data;
  logic [1:0]  out_bytes;

  tfhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_bytes_i (s_axis_tdata[17:16]),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tfhs_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_data_i     (s_axis_tdata[15:0]),
    .in_bytes_i    (s_axis_tdata[17:16]),
    .in_last_i     (s_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_data_o    (out_data),
    .out_bytes_o   (out_bytes),
    .out_last_o    (m_axis_tlast),
    .out_verdict_o (m_axis_tuser)
  );

  assign m_axis_tdata = {6'b0, out_bytes, out_data};

endmodule
`default_nettype wire

[hw/rtl/tfhs_datapath.sv]
// datapath: header buffer, field captures, checksum update and output word register
`default_nettype none
module tfhs_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tfhs_pkg::cmd_t     cmd_i,
  output tfhs_pkg::status_t       status_o,
  input  wire logic [15:0]        in_data_i,
  input  wire logic [1:0]         in_bytes_i,
  input  wire logic               in_last_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [15:0]             out_data_o,
  output logic [1:0]              out_bytes_o,
  output logic                    out_last_o,
  output logic [1:0]              out_verdict_o
);

  localparam int IW = tfhs_pkg::IDX_W;

  logic [15:0] mem [tfhs_pkg::HEADER_BEATS];
  logic [15:0] rdata_q;

  logic [15:0] dst_cfg_q, src_cfg_q;
  logic [7:0]  proto_cfg_q;

  logic [IW-1:0] idx_q, fl_addr_q, fl_cnt_q, fl_cnt_d;
  logic [3:0]    ihl_q;
  logic [15:0]   tot_q, newtot_q, pw_q, newpw_q, csum_q, prev_q;
  logic [17:0]   pre_q;
  logic          rewrite_q;
  logic [3:0]    strip_q;
  logic [1:0]    fl_bytes_q;
  logic          fl_last_q;
  tfhs_pkg::verdict_e fl_verdict_q, fwd_verdict_q;

  logic          out_valid_q, out_last_q;
  logic [15:0]   out_data_q;
  logic [1:0]    out_bytes_q, nb;
  tfhs_pkg::verdict_e out_verdict_q;

  logic [6:0]    ports_pos;
  logic [18:0]   sum;
  logic [16:0]   fold1;
  logic [15:0]   fold2, newpw, subst;
  logic          fl_final;

  assign nb        = (in_last_i && in_bytes_i == 2'd1) ? 2'd1 : 2'd2;
  assign ports_pos = 7'd8 + {2'b0, ihl_q, 1'b0};
  assign newpw     = {pw_q[15:8], proto_cfg_q};
  assign sum       = {1'b0, pre_q} + {3'b0, newpw};
  assign fold1     = {1'b0, sum[15:0]} + {14'b0, sum[18:16]};
  assign fold2     = fold1[15:0] + {15'b0, fold1[16]};
  assign fl_final  = (fl_addr_q == fl_cnt_q - IW'(1));

  always_comb begin
    unique case (cmd_i.cnt_sel)
      tfhs_pkg::CNT_HDR: fl_cnt_d = IW'(7) + {1'b0, ihl_q, 1'b0};
      tfhs_pkg::CNT_ALL: fl_cnt_d = IW'(9) + {1'b0, ihl_q, 1'b0};
      default:           fl_cnt_d = idx_q + IW'(1);
    endcase
  end

  // rewritten ip fields replace the buffered ones on the way out
  always_comb begin
    subst = rdata_q;
    if (rewrite_q) begin
      if (fl_addr_q == tfhs_pkg::BEAT_TOT)   subst = newtot_q;
      if (fl_addr_q == tfhs_pkg::BEAT_PROTO) subst = newpw_q;
      if (fl_addr_q == tfhs_pkg::BEAT_CSUM)  subst = csum_q;
    end
  end

  always_comb begin
    status_o.at_etype    = (idx_q == tfhs_pkg::BEAT_ETYPE);
    status_o.at_ip_end   = (idx_q == tfhs_pkg::BEAT_LAST_IP);
    status_o.at_ports    = (idx_q > tfhs_pkg::BEAT_LAST_IP) && ({1'b0, idx_q} == ports_pos);
    status_o.is_ip       = (in_data_i == tfhs_pkg::ETHERTYPE_IPV4);
    status_o.hdr_ok      = (pw_q[7:0] == tfhs_pkg::PROTO_TCP) && (ihl_q >= 4'd5)
                           && (ports_pos < 7'(tfhs_pkg::HEADER_BEATS));
    status_o.ports_match = (in_data_i == dst_cfg_q) && (prev_q == src_cfg_q);
    status_o.tot_short   = tot_q < ({10'b0, ihl_q, 2'b0} + 16'(tfhs_pkg::STRIP_BYTES));
    status_o.strip_done  = (strip_q <= 4'd1);
    status_o.fl_final    = fl_final;
    status_o.fl_last     = fl_last_q;
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coll_acc) begin
      mem[idx_q] <= in_data_i;
    end
    rdata_q <= mem[fl_addr_q];
  end

  // captured fields, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.coll_acc) begin
      prev_q <= in_data_i;
      if (idx_q == tfhs_pkg::BEAT_TOT) begin
        tot_q    <= in_data_i;
        newtot_q <= in_data_i - 16'(tfhs_pkg::STRIP_BYTES);
      end
      if (idx_q == tfhs_pkg::BEAT_PROTO) pw_q <= in_data_i;
      if (idx_q == tfhs_pkg::BEAT_CSUM) begin
        pre_q <= {2'b0, ~in_data_i} + {2'b0, ~tot_q} + {2'b0, newtot_q} + {2'b0, ~pw_q};
      end
    end
    if (cmd_i.rewrite) begin
      newpw_q <= newpw;
      csum_q  <= ~fold2;
    end
    if (cmd_i.fl_start) begin
      fl_cnt_q   <= fl_cnt_d;
      fl_bytes_q <= cmd_i.fl_bytes;
      fl_verdict_q <= cmd_i.fl_verdict;
    end
    if (cmd_i.fwd_emit) begin
      out_data_q    <= in_data_i;
      out_bytes_q   <= nb;
      out_last_q    <= in_last_i;
      out_verdict_q <= in_last_i ? fwd_verdict_q : tfhs_pkg::VERDICT_PASS;
    end else if (cmd_i.fl_load) begin
      out_data_q    <= subst;
      out_bytes_q   <= fl_final ? fl_bytes_q : 2'd2;
      out_last_q    <= fl_final && fl_last_q;
      out_verdict_q <= (fl_final && fl_last_q) ? fl_verdict_q : tfhs_pkg::VERDICT_PASS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_cfg_q     <= 16'd179;
      src_cfg_q     <= 16'd540;
      proto_cfg_q   <= tfhs_pkg::PROTO_UDP;
      idx_q         <= '0;
      ihl_q         <= '0;
      strip_q       <= '0;
      rewrite_q     <= 1'b0;
      fl_addr_q     <= '0;
      fl_last_q     <= 1'b0;
      fwd_verdict_q <= tfhs_pkg::VERDICT_PASS;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tfhs_pkg::CFG_DST_PORT:    dst_cfg_q   <= cfg_data_i;
          tfhs_pkg::CFG_SRC_PORT:    src_cfg_q   <= cfg_data_i;
          tfhs_pkg::CFG_INNER_PROTO: proto_cfg_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.coll_acc) begin
        idx_q <= idx_q + IW'(1);
        if (idx_q == tfhs_pkg::BEAT_VIHL) ihl_q <= in_data_i[11:8];
      end
      if (cmd_i.rewrite) begin
        rewrite_q <= 1'b1;
        strip_q   <= 4'(tfhs_pkg::STRIP_BEATS - 2);
      end
      if (cmd_i.strip_acc && strip_q != 4'd0) strip_q <= strip_q - 4'd1;
      if (cmd_i.fl_start) begin
        fl_addr_q     <= '0;
        fl_last_q     <= cmd_i.fl_last;
        fwd_verdict_q <= cmd_i.fl_verdict;
      end else if (cmd_i.fl_load) begin
        fl_addr_q <= fl_addr_q + IW'(1);
      end
      if (cmd_i.new_frame) begin
        idx_q     <= '0;
        ihl_q     <= '0;
        strip_q   <= '0;
        rewrite_q <= 1'b0;
      end
      if (cmd_i.fwd_emit || cmd_i.fl_load) out_valid_q <= 1'b1;
      else if (out_ready_i)                out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_data_q;
  assign out_bytes_o   = out_bytes_q;
  assign out_last_o    = out_last_q;
  assign out_verdict_o = out_verdict_q;

endmodule
`default_nettype wire

[hw/rtl/tfhs_ctrl.sv]
// controller: frame state machine deciding what each word does
`default_nettype none
module tfhs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [1:0]         in_bytes_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  input  wire tfhs_pkg::status_t  status_i,
  output tfhs_pkg::cmd_t          cmd_o
);

  tfhs_pkg::state_e state_q, state_d;
  logic acc, partial;
  logic [1:0] nb;

  assign in_ready_o = (state_q == tfhs_pkg::ST_COLLECT || state_q == tfhs_pkg::ST_STRIP
                       || state_q == tfhs_pkg::ST_FWD) && status_i.out_free;
  assign acc     = in_valid_i && in_ready_o;
  assign partial = in_last_i && in_bytes_i == 2'd1;
  assign nb      = partial ? 2'd1 : 2'd2;

  // outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.cnt_sel    = tfhs_pkg::CNT_SEEN;
    cmd_o.fl_verdict = tfhs_pkg::VERDICT_PASS;
    cmd_o.fl_bytes   = nb;
    cmd_o.fl_last    = in_last_i;
    unique case (state_q)
      tfhs_pkg::ST_COLLECT: begin
        if (acc) begin
          cmd_o.coll_acc = 1'b1;
          if (status_i.at_etype && !partial && !status_i.is_ip) begin
            cmd_o.fl_start = 1'b1;
          end else if (status_i.at_ip_end && !partial && !status_i.hdr_ok) begin
            cmd_o.fl_start = 1'b1;
          end else if (status_i.at_ports && !partial) begin
            if (!status_i.ports_match) begin
              cmd_o.fl_start = 1'b1;
            end else if (status_i.tot_short) begin
              cmd_o.fl_start   = 1'b1;
              cmd_o.fl_verdict = tfhs_pkg::VERDICT_DROP;
            end else begin
              cmd_o.rewrite = 1'b1;
              if (in_last_i) begin
                cmd_o.fl_start   = 1'b1;
                cmd_o.fl_bytes   = 2'd2;
                cmd_o.fl_verdict = tfhs_pkg::VERDICT_DROP;
              end
            end
          end else if (in_last_i) begin
            cmd_o.fl_start   = 1'b1;
            cmd_o.fl_verdict = tfhs_pkg::VERDICT_DROP;
          end
        end
      end
      tfhs_pkg::ST_STRIP: begin
        if (acc) begin
          cmd_o.strip_acc = 1'b1;
          cmd_o.fl_bytes  = 2'd2;
          if (status_i.strip_done && !partial) begin
            cmd_o.fl_start   = 1'b1;
            cmd_o.cnt_sel    = tfhs_pkg::CNT_HDR;
            cmd_o.fl_verdict = tfhs_pkg::VERDICT_UNFUN;
          end else if (in_last_i) begin
            cmd_o.fl_start   = 1'b1;
            cmd_o.cnt_sel    = tfhs_pkg::CNT_ALL;
            cmd_o.fl_verdict = tfhs_pkg::VERDICT_DROP;
          end
        end
      end
      tfhs_pkg::ST_FWD: begin
        if (acc) begin
          cmd_o.fwd_emit  = 1'b1;
          cmd_o.new_frame = in_last_i;
        end
      end
      tfhs_pkg::ST_FLUSH_LD: begin
        if (status_i.out_free) begin
          cmd_o.fl_load   = 1'b1;
          cmd_o.new_frame = status_i.fl_final && status_i.fl_last;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tfhs_pkg::ST_COLLECT: begin
        if (cmd_o.fl_start)     state_d = tfhs_pkg::ST_FLUSH_RD;
        else if (cmd_o.rewrite) state_d = tfhs_pkg::ST_STRIP;
      end
      tfhs_pkg::ST_STRIP: begin
        if (cmd_o.fl_start) state_d = tfhs_pkg::ST_FLUSH_RD;
      end
      tfhs_pkg::ST_FWD: begin
        if (acc && in_last_i) state_d = tfhs_pkg::ST_COLLECT;
      end
      tfhs_pkg::ST_FLUSH_RD: state_d = tfhs_pkg::ST_FLUSH_LD;
      tfhs_pkg::ST_FLUSH_LD: begin
        if (status_i.out_free) begin
          if (!status_i.fl_final)    state_d = tfhs_pkg::ST_FLUSH_RD;
          else if (status_i.fl_last) state_d = tfhs_pkg::ST_COLLECT;
          else                       state_d = tfhs_pkg::ST_FWD;
        end
      end
      default: state_d = tfhs_pkg::ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfhs_pkg::ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_flush_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tfhs_pkg::ST_FLUSH_LD && !status_i.out_free)
      |=> state_q == tfhs_pkg::ST_FLUSH_LD)
    else $error("flush left while output stalled");
  a_flush_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fl_start |=> state_q == tfhs_pkg::ST_FLUSH_RD)
    else $error("flush start did not enter read");
  a_rewrite_in_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rewrite |-> state_q == tfhs_pkg::ST_COLLECT && acc)
    else $error("rewrite outside header collection");
  a_no_accept_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tfhs_pkg::ST_FLUSH_RD || state_q == tfhs_pkg::ST_FLUSH_LD) |-> !in_ready_o)
    else $error("word accepted during flush");
`endif

endmodule
`default_nettype wire

[tb/sv/tcp_funnel_header_stripper_test.sv]
// testbench of the tcp funnel header stripper: stream stimulus, predictor and checker
`timescale 1ns / 1ps
`default_nettype none
module tcp_funnel_header_stripper_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 200;   // a full header flush with stalls fits well inside
  localparam int RANDOM_WORDS = 15;

  // frame kinds the generator knows
  localparam int K_FUNNEL    = 0;
  localparam int K_NOT_IP    = 1;
  localparam int K_NOT_TCP   = 2;
  localparam int K_PORT_MISS = 3;
  localparam int K_SMALL_IHL = 4;
  localparam int K_SHORT_TOT = 5;
  localparam int K_CUT_HDR   = 6;
  localparam int K_CUT_STRIP = 7;
  localparam int K_NOISE     = 8;

  typedef enum {
    FM_COLLECT, FM_PASS, FM_UNFUN, FM_DROP, FM_STRIP
  } frame_mode_e;

  typedef struct packed {
    logic [15:0] data;
    logic [1:0]  nbytes;
    logic        last;
    logic [1:0]  verdict;
  } out_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [15:0] beat_data, [17:16] beat_bytes
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [15:0] out_data, [17:16] out_bytes
  logic [1:0]  m_axis_tuser;        // [1:0] verdict
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  tcp_funnel_header_stripper i_dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow copy of the registers and of the frame state
  logic [15:0] dst_port_reg, src_port_reg;
  logic [7:0]  inner_proto_reg;
  logic [15:0] hdr_buf [tfhs_pkg::HEADER_BEATS];
  int          next_beat, ihl_words, strip_left;
  frame_mode_e fmode;

  out_word_t expected_words[$];
  int        mismatches = 0;
  int        cycles = 0;
  byte       frame_bytes[$];

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // random gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink side: ready toggles in stretches of random length
  int ready_hold = 0;
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 30);
    end
  end

  // compare every accepted output word with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_word_t exp_w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word data=%h bytes=%0d last=%b verdict=%0d",
                   m_axis_tdata[15:0], m_axis_tdata[17:16], m_axis_tlast, m_axis_tuser);
      end else begin
        exp_w = expected_words.pop_front();
        if (m_axis_tdata[15:0] !== exp_w.data || m_axis_tdata[17:16] !== exp_w.nbytes ||
            m_axis_tlast !== exp_w.last || m_axis_tuser !== exp_w.verdict) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected data=%h bytes=%0d last=%b verdict=%0d,",
                      " got data=%h bytes=%0d last=%b verdict=%0d"},
                     exp_w.data, exp_w.nbytes, exp_w.last, exp_w.verdict,
                     m_axis_tdata[15:0], m_axis_tdata[17:16], m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  task automatic restart_frame();
    next_beat = 0;
    ihl_words = 0;
    strip_left = 0;
    fmode = FM_COLLECT;
  endtask

  // queue buffered header words 0..count-1, the final one closing the frame if asked
  task automatic emit_header(int count, logic [1:0] last_bytes, bit closes, logic [1:0] v);
    out_word_t w;
    if (count > tfhs_pkg::HEADER_BEATS) count = tfhs_pkg::HEADER_BEATS;
    for (int i = 0; i < count; i++) begin
      w.data = hdr_buf[i];
      w.last = closes && (i + 1 == count);
      w.nbytes = w.last ? last_bytes : 2'd2;
      w.verdict = w.last ? v : tfhs_pkg::VERDICT_PASS;
      expected_words.push_back(w);
    end
  endtask

  task automatic release_header(int count, logic [1:0] nb, bit last, frame_mode_e m,
                                logic [1:0] v);
    emit_header(count, nb, last, v);
    if (last) restart_frame();
    else fmode = m;
  endtask

  // predicts the output words caused by one accepted input word
  task automatic predict_word(logic [15:0] d, logic [1:0] b, bit last);
    logic [1:0]  nb;
    bit          partial;
    int          ihl, idx, n;
    logic [31:0] sum;
    logic [15:0] tot, new_tot, old_pw, new_pw, csum;
    out_word_t   w;
    nb = (last && b == 2'd1) ? 2'd1 : 2'd2;
    partial = (nb == 2'd1);
    ihl = ihl_words;
    if (fmode == FM_PASS || fmode == FM_UNFUN || fmode == FM_DROP) begin
      w.data = d;
      w.nbytes = nb;
      w.last = last;
      w.verdict = !last ? tfhs_pkg::VERDICT_PASS :
                  fmode == FM_PASS ? tfhs_pkg::VERDICT_PASS :
                  fmode == FM_UNFUN ? tfhs_pkg::VERDICT_UNFUN : tfhs_pkg::VERDICT_DROP;
      expected_words.push_back(w);
      if (last) restart_frame();
      return;
    end
    if (fmode == FM_STRIP) begin
      if (strip_left > 0) strip_left--;
      if (strip_left == 0 && !partial) begin
        release_header(7 + 2 * ihl, 2'd2, last, FM_UNFUN, tfhs_pkg::VERDICT_UNFUN);
      end else if (last) begin
        emit_header(9 + 2 * ihl, 2'd2, 1'b1, tfhs_pkg::VERDICT_DROP);
        restart_frame();
      end
      return;
    end
    // collecting the header
    idx = next_beat;
    n = idx + 1;
    if (idx >= tfhs_pkg::HEADER_BEATS) begin
      release_header(tfhs_pkg::HEADER_BEATS, nb, last, FM_PASS, tfhs_pkg::VERDICT_PASS);
      return;
    end
    hdr_buf[idx] = d;
    if (idx == 6 && !partial && d != tfhs_pkg::ETHERTYPE_IPV4) begin
      release_header(n, nb, last, FM_PASS, tfhs_pkg::VERDICT_PASS);
      return;
    end
    if (idx == 7) ihl_words = d[11:8];
    if (idx == 16 && !partial) begin
      if (hdr_buf[11][7:0] != tfhs_pkg::PROTO_TCP || ihl < 5 ||
          8 + 2 * ihl >= tfhs_pkg::HEADER_BEATS) begin
        release_header(n, nb, last, FM_PASS, tfhs_pkg::VERDICT_PASS);
        return;
      end
    end
    if (idx > 16 && idx == 8 + 2 * ihl && !partial) begin
      if (d != dst_port_reg || hdr_buf[idx - 1] != src_port_reg) begin
        release_header(n, nb, last, FM_PASS, tfhs_pkg::VERDICT_PASS);
        return;
      end
      tot = hdr_buf[8];
      if (tot < 4 * ihl + tfhs_pkg::STRIP_BYTES) begin
        release_header(n, nb, last, FM_DROP, tfhs_pkg::VERDICT_DROP);
        return;
      end
      // incremental one's complement checksum update
      new_tot = tot - 16'(tfhs_pkg::STRIP_BYTES);
      old_pw = hdr_buf[11];
      new_pw = {old_pw[15:8], inner_proto_reg};
      sum = {16'h0, ~hdr_buf[12]} + {16'h0, ~tot} + {16'h0, new_tot} +
            {16'h0, ~old_pw} + {16'h0, new_pw};
      sum = (sum & 32'hFFFF) + (sum >> 16);
      sum = (sum & 32'hFFFF) + (sum >> 16);
      csum = ~sum[15:0];
      hdr_buf[8] = new_tot;
      hdr_buf[11] = new_pw;
      hdr_buf[12] = csum;
      strip_left = (tfhs_pkg::STRIP_BYTES / 2 - 2) & 15;
      if (last) begin
        emit_header(n, 2'd2, 1'b1, tfhs_pkg::VERDICT_DROP);
        restart_frame();
        return;
      end
      fmode = FM_STRIP;
      if (strip_left == 0)
        release_header(7 + 2 * ihl, 2'd2, 1'b0, FM_UNFUN, tfhs_pkg::VERDICT_UNFUN);
      return;
    end
    if (last) begin
      emit_header(n, nb, 1'b1, tfhs_pkg::VERDICT_DROP);
      restart_frame();
      return;
    end
    next_beat = n & 63;
  endtask

  // drives one word and predicts its results once it is taken
  task automatic send_word(logic [15:0] d, logic [1:0] b, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, b, d};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(d, b, last);
  endtask

  // holds the source until every expected word has come
  task automatic drain(bit extra);
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    if (extra) repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    drain(1'b1);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      tfhs_pkg::CFG_DST_PORT:    dst_port_reg = value;
      tfhs_pkg::CFG_SRC_PORT:    src_port_reg = value;
      tfhs_pkg::CFG_INNER_PROTO: inner_proto_reg = value[7:0];
      default: ;
    endcase
  endtask

  function automatic byte rnd_byte();
    return byte'($urandom_range(0, 255));
  endfunction

  // builds a frame of the given kind into frame_bytes
  task automatic build_frame(int kind);
    int ihl, payload, tot, cut, sel;
    logic [15:0] etype, sport, dport;
    logic [7:0]  proto;
    frame_bytes.delete();
    if (kind == K_NOISE) begin
      repeat ($urandom_range(1, 40)) frame_bytes.push_back(rnd_byte());
      return;
    end
    // mostly the plain ip header, now and then options up to the largest one
    sel = $urandom_range(0, 7);
    if (kind == K_SMALL_IHL) ihl = (sel == 0) ? 4 : $urandom_range(0, 4);
    else if (sel == 0) ihl = 15;
    else if (sel == 1) ihl = $urandom_range(6, 14);
    else ihl = 5;
    payload = $urandom_range(0, 7);
    tot = ihl * 4 + tfhs_pkg::STRIP_BYTES + payload;
    if (kind == K_SHORT_TOT) tot = $urandom_range(0, ihl * 4 + tfhs_pkg::STRIP_BYTES - 1);
    else if ($urandom_range(0, 7) == 0)
      tot = $urandom_range(ihl * 4 + tfhs_pkg::STRIP_BYTES, 65535);
    etype = tfhs_pkg::ETHERTYPE_IPV4;
    if (kind == K_NOT_IP) begin
      etype = 16'($urandom_range(0, 65535));
      if (etype == tfhs_pkg::ETHERTYPE_IPV4) etype = 16'h86DD;
    end
    proto = tfhs_pkg::PROTO_TCP;
    if (kind == K_NOT_TCP)
      proto = ($urandom_range(0, 1) == 0) ? tfhs_pkg::PROTO_UDP : 8'($urandom_range(7, 255));
    sport = src_port_reg;
    dport = dst_port_reg;
    if (kind == K_PORT_MISS) begin
      if ($urandom_range(0, 1) == 0) sport ^= 16'(1 << $urandom_range(0, 15));
      else dport ^= 16'(1 << $urandom_range(0, 15));
    end
    repeat (12) frame_bytes.push_back(rnd_byte());
    frame_bytes.push_back(etype[15:8]);
    frame_bytes.push_back(etype[7:0]);
    frame_bytes.push_back({4'h4, 4'(ihl)});
    frame_bytes.push_back(rnd_byte());
    frame_bytes.push_back(8'(tot >> 8));
    frame_bytes.push_back(8'(tot));
    repeat (5) frame_bytes.push_back(rnd_byte());
    frame_bytes.push_back(proto);
    repeat (2) frame_bytes.push_back(rnd_byte());   // old checksum
    // addresses and options; a small ihl still leaves the two address words
    repeat ((ihl < 5 ? 5 : ihl) * 4 - 12) frame_bytes.push_back(rnd_byte());
    frame_bytes.push_back(sport[15:8]);
    frame_bytes.push_back(sport[7:0]);
    frame_bytes.push_back(dport[15:8]);
    frame_bytes.push_back(dport[7:0]);
    repeat (tfhs_pkg::STRIP_BYTES - 4 + payload) frame_bytes.push_back(rnd_byte());
    // frames that pass or carry a short total length are cut up to three words after their deciding word
    cut = frame_bytes.size();
    case (kind)
      K_NOT_IP:                cut = 2 * $urandom_range(7, 10);
      K_NOT_TCP, K_SMALL_IHL:  cut = 2 * $urandom_range(17, 19);
      K_PORT_MISS, K_SHORT_TOT: cut = 2 * (9 + 2 * ihl) + 2 * $urandom_range(0, 2);
      K_CUT_HDR:               cut = $urandom_range(1, 2 * (9 + 2 * ihl));
      K_CUT_STRIP:             cut = $urandom_range(2 * (9 + 2 * ihl), 2 * (16 + 2 * ihl));
      default: ;
    endcase
    if (cut > frame_bytes.size()) cut = frame_bytes.size();
    while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
  endtask

  // sends frame_bytes as words; non-final words carry random byte counts
  task automatic send_frame();
    int words;
    logic [15:0] d;
    logic [1:0]  b;
    bit odd;
    words = (frame_bytes.size() + 1) / 2;
    odd = frame_bytes.size() % 2;
    for (int i = 0; i < words; i++) begin
      d[15:8] = frame_bytes[2 * i];
      d[7:0] = (2 * i + 1 < frame_bytes.size()) ? frame_bytes[2 * i + 1] : rnd_byte();
      if (i == words - 1) begin
        if (odd) b = 2'd1;
        else begin
          case ($urandom_range(0, 2))
            0: b = 2'd0;
            1: b = 2'd2;
            default: b = 2'd3;
          endcase
        end
      end else begin
        b = 2'($urandom_range(0, 3));
      end
      send_word(d, b, i == words - 1);
    end
  endtask

  task automatic run_frame(int kind);
    build_frame(kind);
    send_frame();
  endtask

  // a funneled frame under the reset defaults
  task automatic test_default_funnel();
    run_frame(K_FUNNEL);
  endtask

  // frames that pass unchanged
  task automatic test_pass_through();
    run_frame(K_NOT_IP);
    run_frame(K_NOT_TCP);
    run_frame(K_PORT_MISS);
    run_frame(K_SMALL_IHL);
  endtask

  // frames that end early or carry a short total length
  task automatic test_drop_cases();
    run_frame(K_CUT_HDR);
    run_frame(K_SHORT_TOT);
    run_frame(K_CUT_STRIP);
    // a single odd byte
    send_word(16'hFFFF, 2'd1, 1'b1);
  endtask

  // register extremes
  task automatic test_reg_extremes();
    write_reg(tfhs_pkg::CFG_DST_PORT, 16'h0000);
    write_reg(tfhs_pkg::CFG_SRC_PORT, 16'hFFFF);
    write_reg(tfhs_pkg::CFG_INNER_PROTO, 16'h00FF);
    run_frame(K_FUNNEL);
    write_reg(tfhs_pkg::CFG_DST_PORT, 16'hFFFF);
    write_reg(tfhs_pkg::CFG_SRC_PORT, 16'h0000);
    write_reg(tfhs_pkg::CFG_INNER_PROTO, 16'h0000);
    run_frame(K_FUNNEL);
  endtask

  // random frames, mostly well formed, under changing registers
  task automatic test_random_frames();
    int sent, r;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        write_reg(tfhs_pkg::CFG_DST_PORT, 16'($urandom_range(0, 65535)));
        write_reg(tfhs_pkg::CFG_SRC_PORT, 16'($urandom_range(0, 65535)));
        write_reg(tfhs_pkg::CFG_INNER_PROTO, 16'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 7) == 0) drain(1'b0);
      r = $urandom_range(0, 99);
      if (r < 50) build_frame(K_FUNNEL);
      else build_frame($urandom_range(K_NOT_IP, K_NOISE));
      sent += (frame_bytes.size() + 1) / 2;
      send_frame();
    end
  endtask

  initial begin
    dst_port_reg = 16'd179;
    src_port_reg = 16'd540;
    inner_proto_reg = tfhs_pkg::PROTO_UDP;
    restart_frame();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_funnel();
    test_pass_through();
    test_drop_cases();
    test_reg_extremes();
    test_random_frames();
    drain(1'b1);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
